[hdl/crc8fd_pkg.sv]
// Package for the CRC-8 checked frame deframer.
// Holds frame marks, status codes, parse phases, the job record and the CRC step.
// No dependencies.
package crc8fd_pkg;

   localparam logic [7:0]  HEAD_MARK = 8'h68;
   localparam logic [7:0]  TAIL_MARK = 8'h16;
   localparam logic [15:0] BROADCAST = 16'h0000;
   localparam logic [7:0]  CRC_POLY  = 8'h8C;

   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;
   localparam logic [0:0]  CSR_IDX_OWN_ADDRESS = 1'b0;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BAD_TAIL,
      ST_BAD_CRC,
      ST_NOT_ADDR,
      ST_TOO_LONG
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_CMD0,
      PH_CMD1,
      PH_ADR0,
      PH_ADR1,
      PH_LEN,
      PH_DATA,
      PH_CRC,
      PH_TAIL
   } phase_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  command_first;
      logic [7:0]  command_second;
      logic [5:0]  payload_length;
      logic        has_data;
      logic        bank;
   } job_type;

   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

[hdl/crc8fd_csr.sv]
// Configuration register file of the deframer: station address.
// APB-style write and read, always ready. Depends on crc8fd_pkg.
module crc8fd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [crc8fd_pkg::PADDR_W-1:0] paddr,
   input  logic [crc8fd_pkg::PDATA_W-1:0] pwdata,
   output logic [crc8fd_pkg::PDATA_W-1:0] prdata,
   output logic                          pready,
   output logic [15:0]                   own_address
);
   import crc8fd_pkg::*;

   logic [15:0] own_address_ff;
   logic [15:0] own_address_in;
   logic        hit_own;

   assign hit_own = (paddr[2:2] == CSR_IDX_OWN_ADDRESS);

   always_comb begin
      own_address_in = own_address_ff;
      if (psel && penable && pwrite && hit_own) begin
         own_address_in = pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
      end else begin
         own_address_ff <= own_address_in;
      end
   end

   assign prdata      = hit_own ? {{(PDATA_W-16){1'b0}}, own_address_ff} : '0;
   assign pready      = 1'b1;
   assign own_address = own_address_ff;

endmodule

[hdl/crc8fd_parser.sv]
// Byte parser of the deframer: header, fields, CRC check, verdict on the tail byte
// (or on an oversized length byte). Writes payload bytes into the drain buffer and
// posts one job per verdict. Depends on crc8fd_pkg.
module crc8fd_parser #(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [7:0]           req_rx_byte,
   input  logic                 req_buffer_start,
   input  logic [15:0]          own_address,
   output logic                 job_valid,
   output crc8fd_pkg::job_type  job,
   input  logic                 job_take,
   output logic                 wr_en,
   output logic [$clog2(2*MAX_PAYLOAD)-1:0] wr_addr,
   output logic [7:0]           wr_data
);
   import crc8fd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned AW    = $clog2(2 * MAX_PAYLOAD);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in;
   logic [15:0]      cmd_ff, cmd_in;
   logic [15:0]      addr_ff, addr_in;
   logic [7:0]       len_ff, len_in;
   logic             wbank_ff, wbank_in;
   logic             job_valid_ff, job_valid_in;
   job_type          job_ff, job_in;

   logic             beat;
   logic [7:0]       crc_step;
   logic [CNT_W-1:0] count_inc;
   status_type       verdict;
   logic [AW-1:0]    idx_ext;

   assign beat      = req_valid && !req_stall;
   assign req_stall = job_valid_ff && !job_take;
   assign crc_step  = crc_feed(crc_ff, req_rx_byte);
   assign count_inc = count_ff + CNT_W'(1);
   assign idx_ext   = AW'(count_ff);

   always_comb begin
      if (req_rx_byte != TAIL_MARK) begin
         verdict = ST_BAD_TAIL;
      end else if (crc_ff != 8'h00) begin
         verdict = ST_BAD_CRC;
      end else if (addr_ff != BROADCAST && addr_ff != own_address) begin
         verdict = ST_NOT_ADDR;
      end else begin
         verdict = ST_OK;
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      crc_in       = crc_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      len_in       = len_ff;
      wbank_in     = wbank_ff;
      job_in       = job_ff;
      job_valid_in = job_valid_ff && !job_take;
      wr_en        = 1'b0;
      wr_addr      = wbank_ff ? AW'(MAX_PAYLOAD) + idx_ext : idx_ext;
      wr_data      = req_rx_byte;
      if (beat) begin
         if (req_buffer_start) begin
            if (req_rx_byte == HEAD_MARK) begin
               phase_in = PH_CMD0;
               count_in = '0;
               crc_in   = '0;
               cmd_in   = '0;
               addr_in  = '0;
               len_in   = '0;
            end else begin
               phase_in = PH_IDLE;
            end
         end else begin
            case (phase_ff)
               PH_CMD0: begin
                  cmd_in[7:0] = req_rx_byte;
                  crc_in      = crc_step;
                  phase_in    = PH_CMD1;
               end
               PH_CMD1: begin
                  cmd_in[15:8] = req_rx_byte;
                  crc_in       = crc_step;
                  phase_in     = PH_ADR0;
               end
               PH_ADR0: begin
                  addr_in[7:0] = req_rx_byte;
                  crc_in       = crc_step;
                  phase_in     = PH_ADR1;
               end
               PH_ADR1: begin
                  addr_in[15:8] = req_rx_byte;
                  crc_in        = crc_step;
                  phase_in      = PH_LEN;
               end
               PH_LEN: begin
                  crc_in   = crc_step;
                  len_in   = req_rx_byte;
                  count_in = '0;
                  if (req_rx_byte > 8'(MAX_PAYLOAD)) begin
                     job_in.status         = ST_TOO_LONG;
                     job_in.command_first  = cmd_ff[7:0];
                     job_in.command_second = cmd_ff[15:8];
                     job_in.payload_length = 6'(MAX_PAYLOAD);
                     job_in.has_data       = 1'b0;
                     job_in.bank           = wbank_ff;
                     job_valid_in          = 1'b1;
                     phase_in              = PH_IDLE;
                  end else if (req_rx_byte != 8'h00) begin
                     phase_in = PH_DATA;
                  end else begin
                     phase_in = PH_CRC;
                  end
               end
               PH_DATA: begin
                  crc_in   = crc_step;
                  wr_en    = 1'b1;
                  count_in = count_inc;
                  if (8'(count_inc) >= len_ff || count_inc >= CNT_W'(MAX_PAYLOAD)) begin
                     phase_in = PH_CRC;
                  end
               end
               PH_CRC: begin
                  crc_in   = crc_ff ^ req_rx_byte;
                  phase_in = PH_TAIL;
               end
               PH_TAIL: begin
                  phase_in              = PH_IDLE;
                  job_in.status         = verdict;
                  job_in.command_first  = cmd_ff[7:0];
                  job_in.command_second = cmd_ff[15:8];
                  job_in.payload_length = len_ff[5:0];
                  job_in.has_data       = (verdict == ST_OK) && (len_ff != 8'h00);
                  job_in.bank           = wbank_ff;
                  job_valid_in          = 1'b1;
                  if (verdict == ST_OK && len_ff != 8'h00) begin
                     wbank_in = !wbank_ff;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         crc_ff       <= '0;
         cmd_ff       <= '0;
         addr_ff      <= '0;
         len_ff       <= '0;
         wbank_ff     <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         cmd_ff       <= cmd_in;
         addr_ff      <= addr_in;
         len_ff       <= len_in;
         wbank_ff     <= wbank_in;
         job_valid_ff <= job_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> (8'(count_ff) < len_ff && count_ff < CNT_W'(MAX_PAYLOAD)))
      else $error("payload index past frame length");

   a_toggle_on_payload_job: assert property (@(posedge clock) disable iff (reset)
      (beat && !req_buffer_start && phase_ff == PH_TAIL && verdict == ST_OK
       && len_ff != 8'h00) |=> (wbank_ff != $past(wbank_ff) && job_ff.has_data))
      else $error("payload job posted without bank swap");

endmodule

[hdl/crc8fd_drain.sv]
// Result drain of the deframer: double-banked payload buffer and result pipeline.
// Plays a job as a run of result beats, one per unstalled cycle; uses crc8fd_pkg.
module crc8fd_drain #(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  crc8fd_pkg::job_type  job,
   output logic                 job_take,
   input  logic                 wr_en,
   input  logic [$clog2(2*MAX_PAYLOAD)-1:0] wr_addr,
   input  logic [7:0]           wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [7:0]           rsp_command_first,
   output logic [7:0]           rsp_command_second,
   output logic [5:0]           rsp_payload_length,
   output logic [7:0]           rsp_data_byte,
   output logic                 rsp_data_valid,
   output logic                 rsp_last
);
   import crc8fd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int unsigned AW    = $clog2(2 * MAX_PAYLOAD);
   localparam int unsigned DEPTH = 2 * MAX_PAYLOAD;

   typedef struct packed {
      status_type status;
      logic [7:0] command_first;
      logic [7:0] command_second;
      logic [5:0] payload_length;
      logic       data_valid;
      logic       last;
   } meta_type;

   logic [7:0]       mem [DEPTH];

   logic             run_active_ff, run_active_in;
   logic [CNT_W-1:0] run_idx_ff, run_idx_in;
   job_type          run_ff, run_in;
   logic             s1_valid_ff, s1_valid_in;
   meta_type         s1_ff;
   logic [7:0]       rd_data_ff;
   logic             out_valid_ff, out_valid_in;
   meta_type         out_ff;
   logic [7:0]       out_data_ff;

   logic             out_load;
   logic             issue;
   logic             issue_last;
   meta_type         issue_meta;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    idx_ext;
   logic             wr_bank;

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign issue      = run_active_ff && (!s1_valid_ff || out_load);
   assign job_take   = job_valid && !run_active_ff;
   assign issue_last = !run_ff.has_data
                       || (7'(run_idx_ff) + 7'd1 == 7'(run_ff.payload_length));
   assign idx_ext    = AW'(run_idx_ff);
   assign rd_addr    = run_ff.bank ? AW'(MAX_PAYLOAD) + idx_ext : idx_ext;
   assign wr_bank    = (wr_addr >= AW'(MAX_PAYLOAD));

   always_comb begin
      issue_meta.status         = run_ff.status;
      issue_meta.command_first  = run_ff.command_first;
      issue_meta.command_second = run_ff.command_second;
      issue_meta.payload_length = run_ff.payload_length;
      issue_meta.data_valid     = run_ff.has_data;
      issue_meta.last           = issue_last;
   end

   always_comb begin
      run_active_in = run_active_ff;
      run_idx_in    = run_idx_ff;
      run_in        = run_ff;
      if (job_take) begin
         run_active_in = 1'b1;
         run_idx_in    = '0;
         run_in        = job;
      end else if (issue) begin
         run_idx_in = run_idx_ff + CNT_W'(1);
         if (issue_last) begin
            run_active_in = 1'b0;
         end
      end
      s1_valid_in = s1_valid_ff;
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff <= 1'b0;
         run_idx_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         run_active_ff <= run_active_in;
         run_idx_ff    <= run_idx_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff <= run_in;
      if (issue) begin
         s1_ff <= issue_meta;
      end
      if (out_load && s1_valid_ff) begin
         out_ff      <= s1_ff;
         out_data_ff <= s1_ff.data_valid ? rd_data_ff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_command_first  = out_ff.command_first;
   assign rsp_command_second = out_ff.command_second;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_data_byte      = out_data_ff;
   assign rsp_data_valid     = out_ff.data_valid;
   assign rsp_last           = out_ff.last;

   a_no_write_into_run: assert property (@(posedge clock) disable iff (reset)
      (wr_en && run_active_ff && run_ff.has_data) |-> (wr_bank != run_ff.bank))
      else $error("payload write into bank being drained");

   a_status_only_single: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.data_valid) |-> (out_ff.last && out_data_ff == 8'h00))
      else $error("status beat not a single zero-data beat");

   a_data_only_ok: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.data_valid) |-> (out_ff.status == ST_OK))
      else $error("payload beat with error status");

endmodule

[hdl/crc8_checked_frame_deframer_top.sv]
// Top level of the CRC-8 checked frame deframer.
// Instantiates crc8fd_csr, crc8fd_parser and crc8fd_drain; depends on crc8fd_pkg.
//
// Usage:
//   req channel: one received byte per beat, req_buffer_start marks the first
//   byte of a buffer. The parser takes one beat per cycle while req_stall is low.
//   rsp channel: a valid frame yields one beat per payload byte, rsp_last on the
//   final one; an empty or rejected frame yields a single status beat.
//   APB-style port: own_address at byte address 0, written while idle.
// Order: a frame's job goes from the job slot to the run register, issue stage and
//   result register after its tail byte (or oversized length byte) is accepted.
// Throughput: one input byte per cycle while req_stall is low; a run drains one
//   beat per cycle while rsp_stall is low. The drain plays one run at a time from
//   a two-bank payload buffer; a finished frame waits in a one-entry job slot and
//   req_stall is high while that slot is full and the drain is still busy.
// Reset: synchronous; parser goes to waiting for a buffer start, job slot and
//   result pipeline empty, own_address zero.
// Receiver stall: rsp_stall holds the result register; the pipeline fills, the
//   job slot stays full and the input is stalled in turn.
module crc8_checked_frame_deframer_top #(
   parameter int unsigned MAX_PAYLOAD = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_rx_byte,
   input  logic                           req_buffer_start,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_command_first,
   output logic [7:0]                     rsp_command_second,
   output logic [5:0]                     rsp_payload_length,
   output logic [7:0]                     rsp_data_byte,
   output logic                           rsp_data_valid,
   output logic                           rsp_last,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [crc8fd_pkg::PADDR_W-1:0] paddr,
   input  logic [crc8fd_pkg::PDATA_W-1:0] pwdata,
   output logic [crc8fd_pkg::PDATA_W-1:0] prdata,
   output logic                           pready
);
   import crc8fd_pkg::*;

   localparam int unsigned AW = $clog2(2 * MAX_PAYLOAD);

   logic [15:0]   own_address;
   logic          job_valid;
   job_type       job;
   logic          job_take;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   crc8fd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .own_address (own_address)
   );

   crc8fd_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .req_buffer_start (req_buffer_start),
      .own_address      (own_address),
      .job_valid        (job_valid),
      .job              (job),
      .job_take         (job_take),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data)
   );

   crc8fd_drain #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_drain (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (job_valid),
      .job                (job),
      .job_take           (job_take),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .wr_data            (wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command_first  (rsp_command_first),
      .rsp_command_second (rsp_command_second),
      .rsp_payload_length (rsp_payload_length),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_data_valid     (rsp_data_valid),
      .rsp_last           (rsp_last)
   );

endmodule
